// ===== hdl/srpg_pkg.sv =====
// ----------------------------------------------------------------------------
// Stepper ramp period generator package
// Shared widths, codes and beat types of the stepper ramp period generator.
// ----------------------------------------------------------------------------
package srpg_pkg;

  localparam int ACCEL_DEPTH = 128;
  localparam int DECEL_DEPTH = 512;
  localparam int PERIOD_BITS = 16;

  localparam int ACCEL_AW = $clog2(ACCEL_DEPTH);
  localparam int DECEL_AW = $clog2(DECEL_DEPTH);
  localparam int TBL_MAX  = (ACCEL_DEPTH > DECEL_DEPTH) ? ACCEL_DEPTH : DECEL_DEPTH;
  localparam int PTR_W    = $clog2(TBL_MAX + 1);

  localparam int INDEX_W  = 9;
  localparam int COUNT_W  = 32;
  localparam int ACCEL_LEN_W = 8;
  localparam int DECEL_LEN_W = 10;
  localparam int CRUISE_W    = 16;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;

  localparam logic [ACCEL_LEN_W-1:0] ACCEL_LEN_RST = ACCEL_LEN_W'(88);
  localparam logic [DECEL_LEN_W-1:0] DECEL_LEN_RST = DECEL_LEN_W'(400);
  localparam logic [CRUISE_W-1:0]    CRUISE_RST    = CRUISE_W'(2000);

  typedef enum logic [1:0] {
    ACT_WR_ACCEL = 2'd0,
    ACT_WR_DECEL = 2'd1,
    ACT_START    = 2'd2,
    ACT_STEP     = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    PH_ACCEL = 2'd0,
    PH_CONST = 2'd1,
    PH_DECEL = 2'd2
  } ph_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACCEL_LEN = 2'd0,
    REG_DECEL_LEN = 2'd1,
    REG_CRUISE    = 2'd2
  } reg_e;

  typedef struct packed {
    logic [1:0]             action;
    logic [INDEX_W-1:0]     table_index;
    logic [PERIOD_BITS-1:0] table_value;
    logic [COUNT_W-1:0]     step_count;
    logic                   profile;
    logic                   direction;
  } in_t;

  typedef struct packed {
    logic [PERIOD_BITS-1:0] period;
    logic                   move_direction;
    logic [1:0]             phase;
    logic                   last_step;
  } out_t;

  typedef struct packed {
    logic       is_step;
    logic [1:0] phase;
    logic       profile;
    logic       direction;
    logic       last;
  } s1_t;

endpackage

// ===== hdl/stepper_ramp_period_generator_core.sv =====
// ----------------------------------------------------------------------------
// Stepper ramp period generator core
// Returns the timer period and last-step mark for each step of a move.
// ----------------------------------------------------------------------------
// Usage: input beats carry an action. Table writes load the acceleration or
// deceleration table, a start beat sets up a move, and each step request
// during an active move returns one output beat with the period, the latched
// direction, the phase and a last-step mark. Other beats return nothing.
// Three length and cruise registers are written through the plain config port
// by the user only while the block is idle; the block does not enforce it.
// An accepted step request is registered in the table read stage and moves
// on into the output register once it is free. One beat is accepted every
// cycle while the output does not stall; the rate is set by the single
// table read port, whose registered data feeds the output register.
// Reset clears the move state and loads the register defaults; table
// contents stay undefined until written and no clearing pass is run.
// When the receiver stalls, the output beat holds, the table read stage
// fills, and then the input is stalled until the output drains.
// ----------------------------------------------------------------------------
module stepper_ramp_period_generator_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  srpg_pkg::in_t                    in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output srpg_pkg::out_t                   out_data_o,
  input  logic                             cfg_we_i,
  input  logic [srpg_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [srpg_pkg::CFG_W-1:0]       cfg_data_i
);
  import srpg_pkg::*;

  logic [PERIOD_BITS-1:0] accel_mem [ACCEL_DEPTH];
  logic [PERIOD_BITS-1:0] decel_mem [DECEL_DEPTH];
  logic [PERIOD_BITS-1:0] accel_rd_q, decel_rd_q;

  logic [ACCEL_LEN_W-1:0] accel_len_q;
  logic [DECEL_LEN_W-1:0] decel_len_q;
  logic [CRUISE_W-1:0]    cruise_q;

  logic               active_q, active_d;
  logic               prof_q, prof_d;
  logic               dir_q, dir_d;
  ph_e                phase_q, phase_d;
  logic [PTR_W-1:0]   ptr_q, ptr_d;
  logic [COUNT_W-1:0] rem_q, rem_d;
  logic [COUNT_W-1:0] hold_q, hold_d;
  logic [PTR_W-1:0]   ramp_q, ramp_d;
  logic [PERIOD_BITS-1:0] held_q, held_d;

  s1_t  s1_q, s1_new;
  logic s1_vld_q, s1_vld_d, s1_load, s1_adv;
  out_t out_q, out_d;
  logic out_vld_q, out_vld_d, out_free;

  logic in_acc;
  logic [ACCEL_AW-1:0] accel_raddr;
  logic [DECEL_AW-1:0] decel_raddr;
  logic [PTR_W-1:0]    accel_eff, decel_eff, sym_r, cru_d;
  logic [COUNT_W-1:0]  n, rem_dec;
  logic                sym_ge;
  logic [PERIOD_BITS-1:0] s1_period;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign s1_adv     = s1_vld_q && out_free;
  assign in_stall_o = s1_vld_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign n          = in_data_i.step_count;
  assign rem_dec    = rem_q - COUNT_W'(1);

  always_comb begin
    if (accel_len_q == '0) begin
      accel_eff = PTR_W'(1);
    end else if (32'(accel_len_q) > 32'(ACCEL_DEPTH)) begin
      accel_eff = PTR_W'(ACCEL_DEPTH);
    end else begin
      accel_eff = PTR_W'(accel_len_q);
    end
    if (decel_len_q == '0) begin
      decel_eff = PTR_W'(1);
    end else if (32'(decel_len_q) > 32'(DECEL_DEPTH)) begin
      decel_eff = PTR_W'(DECEL_DEPTH);
    end else begin
      decel_eff = PTR_W'(decel_len_q);
    end
    sym_ge = {1'b0, n} >= (33'(accel_eff) << 1);
    sym_r  = sym_ge ? accel_eff : PTR_W'(n >> 1);
    cru_d  = (n < COUNT_W'(decel_eff)) ? PTR_W'(n) : decel_eff;
  end

  always_comb begin
    active_d    = active_q;
    prof_d      = prof_q;
    dir_d       = dir_q;
    phase_d     = phase_q;
    ptr_d       = ptr_q;
    rem_d       = rem_q;
    hold_d      = hold_q;
    ramp_d      = ramp_q;
    accel_raddr = ptr_q[ACCEL_AW-1:0];
    decel_raddr = ptr_q[DECEL_AW-1:0];
    s1_load     = 1'b0;
    s1_new      = '0;
    if (in_acc) begin
      case (in_data_i.action)
        ACT_START: begin
          prof_d = in_data_i.profile;
          dir_d  = in_data_i.direction;
          ptr_d  = '0;
          if (!in_data_i.profile) begin
            ramp_d = sym_r;
            hold_d = n - (COUNT_W'(sym_r) << 1);
            if (sym_r != '0) begin
              phase_d  = PH_ACCEL;
              rem_d    = COUNT_W'(sym_r);
              active_d = 1'b1;
            end else begin
              accel_raddr = '0;
              s1_load     = 1'b1;
              phase_d     = PH_CONST;
              rem_d       = n;
              active_d    = (n != '0);
            end
          end else begin
            ramp_d = cru_d;
            hold_d = n - COUNT_W'(cru_d);
            if (n != COUNT_W'(cru_d)) begin
              phase_d  = PH_CONST;
              rem_d    = n - COUNT_W'(cru_d);
              active_d = 1'b1;
            end else begin
              phase_d  = PH_DECEL;
              rem_d    = COUNT_W'(cru_d);
              ptr_d    = cru_d - PTR_W'(1);
              active_d = (cru_d != '0);
            end
          end
        end
        ACT_STEP: begin
          if (active_q) begin
            s1_load   = 1'b1;
            rem_d     = rem_dec;
            case (phase_q)
              PH_ACCEL: ptr_d = ptr_q + PTR_W'(1);
              PH_DECEL: begin
                if (ptr_q != '0) begin
                  ptr_d = ptr_q - PTR_W'(1);
                end
              end
              default: ptr_d = ptr_q;
            endcase
            if (rem_dec == '0) begin
              case (phase_q)
                PH_ACCEL: begin
                  if (hold_q != '0) begin
                    phase_d = PH_CONST;
                    rem_d   = hold_q;
                  end else begin
                    phase_d = PH_DECEL;
                    rem_d   = COUNT_W'(ramp_q);
                    ptr_d   = ramp_q - PTR_W'(1);
                  end
                end
                PH_CONST: begin
                  if (ramp_q != '0) begin
                    phase_d = PH_DECEL;
                    rem_d   = COUNT_W'(ramp_q);
                    ptr_d   = ramp_q - PTR_W'(1);
                  end else begin
                    active_d = 1'b0;
                  end
                end
                default: active_d = 1'b0;
              endcase
            end
            s1_new.is_step   = 1'b1;
            s1_new.phase     = phase_q;
            s1_new.profile   = prof_q;
            s1_new.direction = dir_q;
            s1_new.last      = !active_d;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (s1_q.phase)
      PH_ACCEL: s1_period = accel_rd_q;
      PH_CONST: s1_period = s1_q.profile ? cruise_q : held_q;
      default:  s1_period = s1_q.profile ? decel_rd_q : accel_rd_q;
    endcase
    held_d = held_q;
    if (s1_adv) begin
      held_d = s1_q.is_step ? s1_period : accel_rd_q;
    end
    s1_vld_d = s1_vld_q;
    if (s1_load) begin
      s1_vld_d = 1'b1;
    end else if (s1_adv) begin
      s1_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    out_d     = out_q;
    if (out_free) begin
      out_vld_d = s1_adv && s1_q.is_step;
      out_d.period         = s1_period;
      out_d.move_direction = s1_q.direction;
      out_d.phase          = s1_q.phase;
      out_d.last_step      = s1_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (in_data_i.action == ACT_WR_ACCEL) &&
        (32'(in_data_i.table_index) < 32'(ACCEL_DEPTH))) begin
      accel_mem[in_data_i.table_index[ACCEL_AW-1:0]] <= in_data_i.table_value;
    end
    if (s1_load) begin
      accel_rd_q <= accel_mem[accel_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (in_data_i.action == ACT_WR_DECEL) &&
        (32'(in_data_i.table_index) < 32'(DECEL_DEPTH))) begin
      decel_mem[in_data_i.table_index[DECEL_AW-1:0]] <= in_data_i.table_value;
    end
    if (s1_load) begin
      decel_rd_q <= decel_mem[decel_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_q <= s1_new;
    end
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_len_q <= ACCEL_LEN_RST;
      decel_len_q <= DECEL_LEN_RST;
      cruise_q    <= CRUISE_RST;
      active_q    <= 1'b0;
      prof_q      <= 1'b0;
      dir_q       <= 1'b0;
      phase_q     <= PH_ACCEL;
      ptr_q       <= '0;
      rem_q       <= '0;
      hold_q      <= '0;
      ramp_q      <= '0;
      held_q      <= '0;
      s1_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_ACCEL_LEN: accel_len_q <= cfg_data_i[ACCEL_LEN_W-1:0];
          REG_DECEL_LEN: decel_len_q <= cfg_data_i[DECEL_LEN_W-1:0];
          REG_CRUISE:    cruise_q    <= cfg_data_i[CRUISE_W-1:0];
          default: begin
          end
        endcase
      end
      active_q  <= active_d;
      prof_q    <= prof_d;
      dir_q     <= dir_d;
      phase_q   <= phase_d;
      ptr_q     <= ptr_d;
      rem_q     <= rem_d;
      hold_q    <= hold_d;
      ramp_q    <= ramp_d;
      held_q    <= held_d;
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ===== tb/stepper_period_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper period checker
// Watches the input, output and register ports of the ramp period generator,
// keeps its own model of the tables and the move in progress, and compares
// every output beat field by field with the oldest predicted step.
// ----------------------------------------------------------------------------
module stepper_period_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  srpg_pkg::in_t                  in_data_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  srpg_pkg::out_t                 out_data_i,
  input  logic                           cfg_we_i,
  input  logic [srpg_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [srpg_pkg::CFG_W-1:0]     cfg_data_i,
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             checked_o
);

  import srpg_pkg::*;

  logic [PERIOD_BITS-1:0] acc_mem [ACCEL_DEPTH];
  logic [PERIOD_BITS-1:0] dec_mem [DECEL_DEPTH];
  logic [ACCEL_LEN_W-1:0] acc_len_q;
  logic [DECEL_LEN_W-1:0] dec_len_q;
  logic [CRUISE_W-1:0]    cruise_q;

  logic                   move_on;
  logic                   move_prof;
  logic                   move_dir;
  ph_e                    cur_ph;
  int unsigned            tbl_ptr;
  logic [COUNT_W-1:0]     ph_left;
  logic [COUNT_W-1:0]     hold_len;
  logic [COUNT_W-1:0]     ramp_len;
  logic [PERIOD_BITS-1:0] last_period;

  out_t                   due_steps [$];

  task automatic advance_phase();
    while (move_on && ph_left == 0) begin
      case (cur_ph)
        PH_ACCEL: begin
          cur_ph  = PH_CONST;
          ph_left = hold_len;
        end
        PH_CONST: begin
          cur_ph  = PH_DECEL;
          ph_left = ramp_len;
          tbl_ptr = (ramp_len == 0) ? 0 : ramp_len - 1;
        end
        default: begin
          move_on = 1'b0;
        end
      endcase
    end
  endtask

  task automatic begin_move(input in_t b);
    longint unsigned n;
    longint unsigned lim;
    n         = b.step_count;
    move_prof = b.profile;
    move_dir  = b.direction;
    tbl_ptr   = 0;
    move_on   = (n != 0);
    if (!move_prof) begin
      lim = (acc_len_q == 0) ? 1 : ((acc_len_q > ACCEL_DEPTH) ? ACCEL_DEPTH : acc_len_q);
      ramp_len = (n >= 2 * lim) ? COUNT_W'(lim) : COUNT_W'(n / 2);
      hold_len = COUNT_W'(n - 2 * ramp_len);
      cur_ph   = PH_ACCEL;
      ph_left  = ramp_len;
      if (ramp_len == 0) last_period = acc_mem[0];
    end else begin
      lim = (dec_len_q == 0) ? 1 : ((dec_len_q > DECEL_DEPTH) ? DECEL_DEPTH : dec_len_q);
      ramp_len = (n < lim) ? COUNT_W'(n) : COUNT_W'(lim);
      hold_len = COUNT_W'(n - ramp_len);
      cur_ph   = PH_CONST;
      ph_left  = hold_len;
    end
    advance_phase();
  endtask

  task automatic take_step();
    out_t                   r;
    logic [PERIOD_BITS-1:0] per;
    ph_e                    ph_now;
    if (!move_on) return;
    ph_now = cur_ph;
    case (cur_ph)
      PH_ACCEL: begin
        per = acc_mem[tbl_ptr];
        tbl_ptr++;
      end
      PH_CONST: begin
        per = move_prof ? cruise_q : last_period;
      end
      default: begin
        per = move_prof ? dec_mem[tbl_ptr] : acc_mem[tbl_ptr];
        if (tbl_ptr != 0) tbl_ptr--;
      end
    endcase
    last_period = per;
    ph_left--;
    advance_phase();
    r.period         = per;
    r.move_direction = move_dir;
    r.phase          = ph_now;
    r.last_step      = !move_on;
    due_steps.push_back(r);
  endtask

  task automatic apply_beat(input in_t b);
    case (b.action)
      ACT_WR_ACCEL: begin
        if (b.table_index < ACCEL_DEPTH) acc_mem[b.table_index] = b.table_value;
      end
      ACT_WR_DECEL: begin
        if (b.table_index < DECEL_DEPTH) dec_mem[b.table_index] = b.table_value;
      end
      ACT_START: begin
        begin_move(b);
      end
      default: begin
        take_step();
      end
    endcase
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    if (due_steps.size() == 0) begin
      $error("unexpected result beat: period %0d, phase %0d", got.period, got.phase);
      fail_count_o++;
      return;
    end
    want = due_steps.pop_front();
    checked_o++;
    if (got.period !== want.period) begin
      $error("period: expected %0d, got %0d", want.period, got.period);
      fail_count_o++;
    end
    if (got.move_direction !== want.move_direction) begin
      $error("move_direction: expected %0d, got %0d", want.move_direction,
             got.move_direction);
      fail_count_o++;
    end
    if (got.phase !== want.phase) begin
      $error("phase: expected %0d, got %0d", want.phase, got.phase);
      fail_count_o++;
    end
    if (got.last_step !== want.last_step) begin
      $error("last_step: expected %0d, got %0d", want.last_step, got.last_step);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_len_q    = ACCEL_LEN_RST;
      dec_len_q    = DECEL_LEN_RST;
      cruise_q     = CRUISE_RST;
      move_on      = 1'b0;
      move_prof    = 1'b0;
      move_dir     = 1'b0;
      cur_ph       = PH_ACCEL;
      tbl_ptr      = 0;
      ph_left      = '0;
      hold_len     = '0;
      ramp_len     = '0;
      last_period  = '0;
      due_steps.delete();
      fail_count_o = 0;
      checked_o    = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_result(out_data_i);
      if (in_valid_i && !in_stall_i) apply_beat(in_data_i);
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_ACCEL_LEN: acc_len_q = cfg_data_i[ACCEL_LEN_W-1:0];
          REG_DECEL_LEN: dec_len_q = cfg_data_i[DECEL_LEN_W-1:0];
          REG_CRUISE:    cruise_q  = cfg_data_i[CRUISE_W-1:0];
          default: ;
        endcase
      end
      pending_o = due_steps.size();
    end
  end

endmodule

// ===== tb/stepper_ramp_period_generator_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper ramp period generator testbench
// Loads period tables on demand, runs symmetric and cruise moves under several
// length and cruise settings with random sender gaps and receiver stalls, and
// leaves the comparison to the period checker beside the core.
// ----------------------------------------------------------------------------
module stepper_ramp_period_generator_core_tb;

  import srpg_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic                 clk_i;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  in_t                  in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_t                 out_data_o;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_data_i  = '0;

  int fails;
  int pending;
  int checked;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  bit hold_req      = 1'b0;
  bit hold_seen     = 1'b0;
  int hold_left     = 0;
  int cycle_cnt     = 0;

  bit acc_written [ACCEL_DEPTH];
  bit dec_written [DECEL_DEPTH];
  int l_eff       = 88;
  int m_eff       = 400;
  int beats       = 0;
  int work_beats  = 0;
  int moves       = 0;
  int settings    = 1;

  stepper_ramp_period_generator_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  stepper_period_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fails),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen   <= hold_req;
      hold_left   <= 80;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic in_t rand_beat();
    in_t b;
    b.action      = 2'($urandom);
    b.table_index = INDEX_W'($urandom);
    b.table_value = PERIOD_BITS'($urandom);
    b.step_count  = $urandom();
    b.profile     = 1'($urandom);
    b.direction   = 1'($urandom);
    return b;
  endfunction

  task automatic send(input in_t b, input bit counts);
    bit st;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do begin
      @(negedge clk_i);
      st = in_stall_o;
      @(posedge clk_i);
    end while (st);
    beats++;
    if (counts) work_beats++;
  endtask

  task automatic write_entry(input bit dec, input int idx, input logic [PERIOD_BITS-1:0] v);
    in_t b;
    bit  hit;
    b             = rand_beat();
    b.action      = dec ? ACT_WR_DECEL : ACT_WR_ACCEL;
    b.table_index = INDEX_W'(idx);
    b.table_value = v;
    hit           = dec || idx < ACCEL_DEPTH;
    if (hit) begin
      if (dec) dec_written[idx] = 1'b1;
      else acc_written[idx] = 1'b1;
    end
    send(b, hit);
  endtask

  task automatic step_req(input bit counts);
    in_t b;
    b        = rand_beat();
    b.action = ACT_STEP;
    send(b, counts);
  endtask

  task automatic prep_tables(input bit prof, input logic [COUNT_W-1:0] n);
    longint unsigned need;
    if (!prof) begin
      need = (n >= 2 * l_eff) ? l_eff : n / 2;
      if (need == 0) need = 1;
    end else begin
      need = (n < m_eff) ? n : m_eff;
      // A cruise stretch longer than the whole run never reaches the table.
      if (n - need > CYCLE_LIMIT) need = 0;
    end
    for (int i = 0; i < need; i++) begin
      if (prof ? !dec_written[i] : !acc_written[i]) write_entry(prof, i, PERIOD_BITS'($urandom));
    end
  endtask

  task automatic run_move(input bit prof, input logic [COUNT_W-1:0] n, input int steps,
                          input int wr_pct);
    in_t b;
    bit  dec;
    prep_tables(prof, n);
    b            = rand_beat();
    b.action     = ACT_START;
    b.step_count = n;
    b.profile    = prof;
    send(b, 1'b1);
    moves++;
    for (int i = 0; i < steps; i++) begin
      if ($urandom_range(99) < wr_pct) begin
        dec = 1'($urandom);
        write_entry(dec, dec ? $urandom_range(DECEL_DEPTH - 1) : $urandom_range(ACCEL_DEPTH + 20),
                    PERIOD_BITS'($urandom));
      end
      step_req(i < n);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [ACCEL_LEN_W-1:0] al, input logic [DECEL_LEN_W-1:0] dl,
                          input logic [CRUISE_W-1:0] cp, input int snd, input int stl);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_ACCEL_LEN;
    cfg_data_i  <= CFG_W'(al);
    @(posedge clk_i);
    cfg_index_i <= REG_DECEL_LEN;
    cfg_data_i  <= CFG_W'(dl);
    @(posedge clk_i);
    cfg_index_i <= REG_CRUISE;
    cfg_data_i  <= CFG_W'(cp);
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    l_eff         = (al == 0) ? 1 : ((al > ACCEL_DEPTH) ? ACCEL_DEPTH : al);
    m_eff         = (dl == 0) ? 1 : ((dl > DECEL_DEPTH) ? DECEL_DEPTH : dl);
    send_idle_pct = snd;
    stall_pct     = stl;
    settings++;
  endtask

  task automatic run_random(input int budget);
    int                 first;
    int                 r;
    int                 maxn;
    bit                 prof;
    logic [COUNT_W-1:0] n;
    first = work_beats;
    while (work_beats - first < budget) begin
      r    = $urandom_range(99);
      prof = 1'($urandom);
      if (r < 70) begin
        maxn = prof ? m_eff + 4 : 2 * l_eff + 3;
        if (maxn > 40) maxn = 40;
        n = $urandom_range(maxn, 1);
        run_move(prof, n, n + (($urandom_range(9) == 0) ? $urandom_range(2, 1) : 0), 5);
      end else if (r < 85) begin
        n = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(60, 1);
        run_move(prof, n, $urandom_range(8), 5);
      end else begin
        case ($urandom_range(3))
          0: write_entry(1'b0, $urandom_range(DECEL_DEPTH - 1), PERIOD_BITS'($urandom));
          1: write_entry(1'b1, $urandom_range(DECEL_DEPTH - 1), PERIOD_BITS'($urandom));
          2: run_move(prof, $urandom_range(1) ? '0 : $urandom(), 0, 0);
          default: step_req(1'b0);
        endcase
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    step_req(1'b0);
    write_entry(1'b0, 0, 16'hFFFF);
    write_entry(1'b0, 1, 16'h0000);
    write_entry(1'b0, 300, 16'h1111);
    write_entry(1'b1, 0, 16'h0000);
    write_entry(1'b1, 1, 16'hFFFF);
    write_entry(1'b1, 511, 16'hA5A5);
    run_move(1'b0, 0, 1, 0);
    run_move(1'b0, 1, 1, 0);
    run_move(1'b0, 5, 5, 0);
    run_move(1'b1, 2, 2, 0);
    run_move(1'b0, 3, 1, 0);
    run_move(1'b0, 4, 4, 0);

    set_regs(8, 6, 16'h0000, 0, 0);
    hold_req <= ~hold_req;
    run_move(1'b0, 24, 24, 0);
    run_random(60);

    set_regs(0, 0, 16'hFFFF, 53, 0);
    run_random(50);

    set_regs(255, 1023, 16'h1234, 0, 53);
    run_random(50);
    run_move(1'b0, 258, 132, 0);

    set_regs(128, 512, 16'hFFFF, 29, 29);
    run_random(50);

    set_regs(3, 7, CRUISE_W'($urandom), 53, 53);
    run_random(50);

    drain_results();
    $display("Covered %0d input beats and %0d moves over %0d register settings.",
             beats, moves, settings);
    $display("Compared %0d step results under mixed sender gaps and receiver stalls.",
             checked);
    if (fails == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/srpg_pkg.sv
hdl/stepper_ramp_period_generator_core.sv
tb/stepper_period_checker.sv
tb/stepper_ramp_period_generator_core_tb.sv
